// ===== src/clipped_blit_pixel_packer_defines.svh =====
// Assertion helpers for the blit packer, clocked on clk, quiet in reset.
`ifndef CLIPPED_BLIT_PIXEL_PACKER_DEFINES_SVH
`define CLIPPED_BLIT_PIXEL_PACKER_DEFINES_SVH

// Same-cycle implication.
`define CBP_ASSERT_NOW(label, cond, expect_now, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error(msg);

// Next-cycle implication.
`define CBP_ASSERT_NEXT(label, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

// ===== src/cbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cbp_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned MAX_STRIDE = 16384;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // pixel formats
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_XRGB   = 2'd1;

  // register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LINE_STRIDE   = 3'd2;
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd3;
  localparam logic [2:0] REG_RED_SHIFT     = 3'd4;
  localparam logic [2:0] REG_GREEN_SHIFT   = 3'd5;
  localparam logic [2:0] REG_BLUE_SHIFT    = 3'd6;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [14:0] line_stride_bytes;
    logic [1:0]  pixel_format;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } cfg_t;

  // one visible pixel waiting for the back end
  typedef struct packed {
    logic [25:0] row_address;
    logic [12:0] column;
    logic        wide;
    logic        last;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } q_entry_t;

endpackage
`default_nettype wire

// ===== src/cbp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cbp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [12:0] src_width;
  logic [12:0] src_height;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, kind, src_width, src_height, dest_x, dest_y, red, green, blue,
                  input ready);
  modport sink (input valid, kind, src_width, src_height, dest_x, dest_y, red, green, blue,
                output ready);
endinterface

interface cbp_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] write_address;
  logic [31:0] write_data;
  logic        write_wide;
  logic        last_write;

  modport source (output valid, write_address, write_data, write_wide, last_write,
                  input ready);
  modport sink (input valid, write_address, write_data, write_wide, last_write,
                output ready);
endinterface
`default_nettype wire

// ===== src/cbp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_blit_pixel_packer_defines.svh"
module cbp_queue
  import cbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output q_entry_t      head_entry
);

  q_entry_t            store [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CBP_ASSERT_NOW(a_no_push_full, full, !push, "push into full queue")
  `CBP_ASSERT_NOW(a_no_pop_empty, !head_valid, !pop, "pop from empty queue")
  `CBP_ASSERT_NEXT(a_drain_empty, (count == QCNT_W'(1)) && pop && !push, !head_valid,
    "queue not empty after last pop")

endmodule
`default_nettype wire

// ===== src/cbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_blit_pixel_packer_defines.svh"
module cbp_front
  import cbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  cbp_in_if.sink     in_ch,
  input  wire logic  q_full,
  output logic       q_push,
  output q_entry_t   q_entry
);

  logic        active;
  logic [12:0] source_width;
  logic [12:0] clipped_width;
  logic [12:0] clipped_height;
  logic [12:0] column_count;
  logic [12:0] row_count;
  logic [25:0] row_address;

  logic        accept;
  logic [13:0] x_end, y_end;
  logic        over_x, over_y, cw_ok, ch_ok;
  logic [12:0] cw, ch;
  logic [26:0] dy_times_stride;
  logic [25:0] start_address;
  logic [13:0] col_inc, row_inc;
  logic        visible, last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // clip against right and bottom screen edges
  assign x_end  = 14'(in_ch.dest_x) + 14'(in_ch.src_width);
  assign y_end  = 14'(in_ch.dest_y) + 14'(in_ch.src_height);
  assign over_x = x_end > 14'(cfg.screen_width);
  assign over_y = y_end > 14'(cfg.screen_height);
  assign cw     = over_x ? (cfg.screen_width - 13'(in_ch.dest_x)) : in_ch.src_width;
  assign ch     = over_y ? (cfg.screen_height - 13'(in_ch.dest_y)) : in_ch.src_height;
  assign cw_ok  = over_x ? (cfg.screen_width > 13'(in_ch.dest_x)) : (in_ch.src_width != '0);
  assign ch_ok  = over_y ? (cfg.screen_height > 13'(in_ch.dest_y)) : (in_ch.src_height != '0);

  assign dy_times_stride = 27'(in_ch.dest_y) * 27'(cfg.line_stride_bytes);
  assign start_address   = dy_times_stride[25:0]
                         + ((cfg.pixel_format == FMT_RGB565) ? {13'd0, in_ch.dest_x, 1'b0}
                                                              : {12'd0, in_ch.dest_x, 2'b0});

  assign col_inc = 14'(column_count) + 14'd1;
  assign row_inc = 14'(row_count) + 14'd1;
  assign visible = column_count < clipped_width;
  assign last    = visible && (col_inc == 14'(clipped_width)) && (row_inc == 14'(clipped_height));

  assign q_push = accept && (in_ch.kind == KIND_PIXEL) && active && visible
                && ((cfg.pixel_format == FMT_RGB565) || (cfg.pixel_format == FMT_XRGB));

  always_comb begin
    q_entry.row_address = row_address;
    q_entry.column      = column_count;
    q_entry.wide        = (cfg.pixel_format == FMT_XRGB);
    q_entry.last        = last;
    q_entry.red         = in_ch.red;
    q_entry.green       = in_ch.green;
    q_entry.blue        = in_ch.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      source_width   <= '0;
      clipped_width  <= '0;
      clipped_height <= '0;
      column_count   <= '0;
      row_count      <= '0;
      row_address    <= '0;
    end else if (accept) begin
      if (in_ch.kind == KIND_START) begin
        column_count <= '0;
        row_count    <= '0;
        if (cw_ok && ch_ok) begin
          active         <= 1'b1;
          source_width   <= in_ch.src_width;
          clipped_width  <= cw;
          clipped_height <= ch;
          row_address    <= start_address;
        end else begin
          active         <= 1'b0;
          source_width   <= '0;
          clipped_width  <= '0;
          clipped_height <= '0;
          row_address    <= '0;
        end
      end else if (active) begin
        if (last) begin
          active       <= 1'b0;
          column_count <= '0;
          row_count    <= '0;
        end else if (col_inc >= 14'(source_width)) begin
          column_count <= '0;
          row_count    <= row_inc[12:0];
          row_address  <= row_address + 26'(cfg.line_stride_bytes);
          if (row_inc[12:0] >= clipped_height) begin
            active <= 1'b0;
          end
        end else begin
          column_count <= col_inc[12:0];
        end
      end
    end
  end

  `CBP_ASSERT_NEXT(a_last_closes, q_push && last, !active, "blit still open after last pixel")

endmodule
`default_nettype wire

// ===== src/cbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cbp_back
  import cbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     head_valid,
  input  wire q_entry_t head_entry,
  output logic          q_pop,
  cbp_out_if.source     out_ch
);

  logic        out_valid;
  logic [25:0] out_address;
  logic [31:0] out_data;
  logic        out_wide;
  logic        out_last;

  logic [25:0] address_next;
  logic [31:0] data_next;
  logic [15:0] rgb565;

  assign q_pop = head_valid && (!out_valid || out_ch.ready);

  assign address_next = head_entry.row_address
                      + (head_entry.wide ? {11'd0, head_entry.column, 2'b0}
                                         : {12'd0, head_entry.column, 1'b0});

  assign rgb565 = {head_entry.red[7:3], head_entry.green[7:2], head_entry.blue[7:3]};

  always_comb begin
    if (head_entry.wide) begin
      data_next = (32'(head_entry.red) << cfg.red_shift)
                | (32'(head_entry.green) << cfg.green_shift)
                | (32'(head_entry.blue) << cfg.blue_shift);
    end else begin
      data_next = {16'd0, rgb565};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_address <= address_next;
      out_data    <= data_next;
      out_wide    <= head_entry.wide;
      out_last    <= head_entry.last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.write_address = out_address;
  assign out_ch.write_data    = out_data;
  assign out_ch.write_wide    = out_wide;
  assign out_ch.last_write    = out_last;

endmodule
`default_nettype wire

// ===== src/clipped_blit_pixel_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        kind, src_width, src_height, dest_x, dest_y, rgb
// out_ch    out  valid/ready        write_address, write_data, write_wide, last_write
// cfg       in   cfg_write only     cfg_index, cfg_data
//
// One word in per cycle unless the queue is full; pixels are queued, then registered.
// Rate is set by the front counters (one pixel a cycle) and the single output register.
// A start word needs no extra step: the dest_y * stride product sits in the front path.
// Reset (rst, synchronous) closes any blit, empties the queue, loads register defaults.
// An output stall fills the four-word queue; in_ch.ready drops only when it is full.
module clipped_blit_pixel_packer
  import cbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  cbp_in_if.sink           in_ch,
  cbp_out_if.source        out_ch
);

  cfg_t     cfg;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     head_valid;
  q_entry_t push_entry;
  q_entry_t head_entry;

  // screen sizes and stride saturate on write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width      <= 13'd640;
      cfg.screen_height     <= 13'd480;
      cfg.line_stride_bytes <= 15'd2560;
      cfg.pixel_format      <= FMT_XRGB;
      cfg.red_shift         <= 5'd16;
      cfg.green_shift       <= 5'd8;
      cfg.blue_shift        <= 5'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:
          cfg.screen_width <= (cfg_data[12:0] > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_data[12:0];
        REG_SCREEN_HEIGHT:
          cfg.screen_height <= (cfg_data[12:0] > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_data[12:0];
        REG_LINE_STRIDE:
          cfg.line_stride_bytes <= (cfg_data > 15'(MAX_STRIDE)) ? 15'(MAX_STRIDE) : cfg_data;
        REG_PIXEL_FORMAT:  cfg.pixel_format <= cfg_data[1:0];
        REG_RED_SHIFT:     cfg.red_shift    <= cfg_data[4:0];
        REG_GREEN_SHIFT:   cfg.green_shift  <= cfg_data[4:0];
        REG_BLUE_SHIFT:    cfg.blue_shift   <= cfg_data[4:0];
        default:           cfg <= cfg;
      endcase
    end
  end

  // front: geometry, clip, raster counters
  cbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // decoupling queue of visible pixels
  cbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // back: address add, pixel pack, output register
  cbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/clipped_blit_pixel_packer_checker.sv =====
`timescale 1ns / 1ps
module clipped_blit_pixel_packer_checker
  import cbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  cbp_in_if           in_ch,
  cbp_out_if          out_ch,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic [25:0] address;
    logic [31:0] data;
    logic        wide;
    logic        last;
  } fb_write_t;

  fb_write_t pending_writes[$];

  // shadow registers
  logic [12:0] screen_w, screen_h;
  logic [14:0] stride;
  logic [1:0]  fmt;
  logic [4:0]  shift_r, shift_g, shift_b;

  // blit state
  logic [12:0] src_w, clip_w, clip_h, col_cnt, row_cnt;
  logic [25:0] row_addr;
  logic        active;

  function automatic int unsigned pixel_bytes();
    return (fmt == FMT_RGB565) ? 2 : 4;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t checker: %s got %h expected %h", $time, what, got, want);
    failures++;
  endtask

  task automatic load_reg(input logic [2:0] idx, input logic [14:0] val);
    case (idx)
      REG_SCREEN_WIDTH:  screen_w = (val[12:0] > MAX_DIM) ? 13'(MAX_DIM) : val[12:0];
      REG_SCREEN_HEIGHT: screen_h = (val[12:0] > MAX_DIM) ? 13'(MAX_DIM) : val[12:0];
      REG_LINE_STRIDE:   stride = (val > MAX_STRIDE) ? 15'(MAX_STRIDE) : val;
      REG_PIXEL_FORMAT:  fmt = val[1:0];
      REG_RED_SHIFT:     shift_r = val[4:0];
      REG_GREEN_SHIFT:   shift_g = val[4:0];
      REG_BLUE_SHIFT:    shift_b = val[4:0];
      default: ;
    endcase
  endtask

  task automatic open_blit(input logic [12:0] w, h, input logic [11:0] dx, dy);
    int cw, ch;
    cw = (int'(dx) + int'(w) > int'(screen_w)) ? int'(screen_w) - int'(dx) : int'(w);
    ch = (int'(dy) + int'(h) > int'(screen_h)) ? int'(screen_h) - int'(dy) : int'(h);
    col_cnt = '0;
    row_cnt = '0;
    if (cw <= 0 || ch <= 0) begin
      active   = 1'b0;
      src_w    = '0;
      clip_w   = '0;
      clip_h   = '0;
      row_addr = '0;
    end else begin
      src_w    = w;
      clip_w   = 13'(cw);
      clip_h   = 13'(ch);
      // x offset uses the format in force now
      row_addr = 26'(int'(dy) * int'(stride) + int'(dx) * pixel_bytes());
      active   = 1'b1;
    end
  endtask

  task automatic take_pixel(input logic [7:0] r, g, b);
    int        col;
    bit        vis, fin;
    fb_write_t wr;
    if (!active)
      return;
    col = int'(col_cnt);
    vis = col < int'(clip_w);
    fin = vis && (col + 1 == int'(clip_w)) && (int'(row_cnt) + 1 == int'(clip_h));
    if (vis && (fmt == FMT_RGB565 || fmt == FMT_XRGB)) begin
      wr.address = 26'(int'(row_addr) + col * pixel_bytes());
      if (fmt == FMT_RGB565)
        wr.data = {16'h0, r[7:3], g[7:2], b[7:3]};
      else
        wr.data = ({24'h0, r} << shift_r) | ({24'h0, g} << shift_g) | ({24'h0, b} << shift_b);
      wr.wide = (fmt == FMT_XRGB);
      wr.last = fin;
      pending_writes.push_back(wr);
    end
    if (fin) begin
      active  = 1'b0;
      col_cnt = '0;
      row_cnt = '0;
      return;
    end
    col_cnt = col_cnt + 13'd1;
    if (col_cnt >= src_w) begin
      col_cnt  = '0;
      row_cnt  = row_cnt + 13'd1;
      row_addr = row_addr + 26'(stride);
      if (row_cnt >= clip_h)
        active = 1'b0;
    end
  endtask

  task automatic check_write();
    fb_write_t want;
    if (pending_writes.size() == 0) begin
      note_mismatch("write with none expected, address", 32'(out_ch.write_address), '0);
      return;
    end
    want = pending_writes.pop_front();
    if (out_ch.write_address != want.address)
      note_mismatch("write_address", 32'(out_ch.write_address), 32'(want.address));
    if (out_ch.write_data != want.data)
      note_mismatch("write_data", out_ch.write_data, want.data);
    if (out_ch.write_wide != want.wide)
      note_mismatch("write_wide", 32'(out_ch.write_wide), 32'(want.wide));
    if (out_ch.last_write != want.last)
      note_mismatch("last_write", 32'(out_ch.last_write), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      screen_w = 13'd640;
      screen_h = 13'd480;
      stride   = 15'd2560;
      fmt      = FMT_XRGB;
      shift_r  = 5'd16;
      shift_g  = 5'd8;
      shift_b  = 5'd0;
      src_w    = '0;
      clip_w   = '0;
      clip_h   = '0;
      col_cnt  = '0;
      row_cnt  = '0;
      row_addr = '0;
      active   = 1'b0;
      pending_writes.delete();
    end else begin
      if (cfg_write)
        load_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_START)
          open_blit(in_ch.src_width, in_ch.src_height, in_ch.dest_x, in_ch.dest_y);
        else
          take_pixel(in_ch.red, in_ch.green, in_ch.blue);
      end
      if (out_ch.valid && out_ch.ready)
        check_write();
    end
    pending <= pending_writes.size();
  end

endmodule

// ===== tb/clipped_blit_pixel_packer_tb.sv =====
`timescale 1ns / 1ps
module clipped_blit_pixel_packer_tb;
  import cbp_pkg::*;

  // formats the block must swallow without writing
  localparam logic [1:0] FMT_NONE_A = 2'd2;
  localparam logic [1:0] FMT_NONE_B = 2'd3;
  // index with no register behind it
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int TARGET_WORDS  = 1950;
  localparam int CALM_WORDS    = 250;   // tail of the run with no idling
  localparam int SETTLE_CYCLES = 12;    // queue and output register, with margin
  localparam int QUIET_LIMIT   = 3000;  // cycles with no word moving on either side

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;
  int          failures;
  int          pending;

  bit gaps_on;      // sender may insert gaps
  bit stalls_on;    // receiver may drop ready
  int sent_words;   // words accepted on in_ch so far
  int scr_w_now;    // screen size as the block sees it, for shaping geometry
  int scr_h_now;

  cbp_in_if  in_ch();
  cbp_out_if out_ch();

  clipped_blit_pixel_packer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  clipped_blit_pixel_packer_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: ready drops in random bursts while stalls are enabled.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long spell with no word moving either way means the block is hung.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // One word onto in_ch, optionally after a gap. Valid stays high afterwards so
  // back-to-back words go through without a bubble; callers drop it when done.
  task automatic send_word(input logic kind, input logic [12:0] w, h,
                           input logic [11:0] dx, dy, input logic [7:0] r, g, b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.src_width  <= w;
    in_ch.src_height <= h;
    in_ch.dest_x     <= dx;
    in_ch.dest_y     <= dy;
    in_ch.red        <= r;
    in_ch.green      <= g;
    in_ch.blue       <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  // Unused payload fields carry noise: the block must ignore them.
  task automatic send_start(input logic [12:0] w, h, input logic [11:0] dx, dy);
    send_word(KIND_START, w, h, dx, dy, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b);
    send_word(KIND_PIXEL, 13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom),
              r, g, b);
  endtask

  // Hold the sender off until every predicted write has drained, then give
  // any word that makes no write time to clear the pipe.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 15'(val);
    @(posedge clk);
  endtask

  // Full register load while the block is quiet; the open blit (if any) carries on.
  task automatic write_regs(input int sw, sh, stride, fmt, rs, gs, bs);
    settle();
    reg_write(REG_SCREEN_WIDTH, sw);
    reg_write(REG_SCREEN_HEIGHT, sh);
    reg_write(REG_LINE_STRIDE, stride);
    reg_write(REG_PIXEL_FORMAT, fmt);
    reg_write(REG_RED_SHIFT, rs);
    reg_write(REG_GREEN_SHIFT, gs);
    reg_write(REG_BLUE_SHIFT, bs);
    reg_write(REG_UNUSED, int'($urandom_range(0, 32767)));
    cfg_write <= 1'b0;
    scr_w_now = ((sw & 13'h1FFF) > MAX_DIM) ? MAX_DIM : (sw & 13'h1FFF);
    scr_h_now = ((sh & 13'h1FFF) > MAX_DIM) ? MAX_DIM : (sh & 13'h1FFF);
  endtask

  // One blit: start word plus pixels. Most are complete (with a few trailing
  // pixels), some are cut short so the next start abandons them, and some are
  // stray pixels with no start in front.
  task automatic random_blit();
    int w, h, dx, dy, cw, ch, needed, count, pick, mode;
    pick = $urandom_range(0, 19);
    mode = $urandom_range(0, 9);
    w  = $urandom_range(1, 6);
    h  = $urandom_range(1, 4);
    dx = $urandom_range(0, (scr_w_now + 1 > 4095) ? 4095 : scr_w_now + 1);
    dy = $urandom_range(0, (scr_h_now + 1 > 4095) ? 4095 : scr_h_now + 1);
    if (pick == 0) begin
      // very wide source, one row, clipped hard at the right edge
      w  = $urandom_range(0, 8191);
      h  = 1;
      dx = scr_w_now - int'($urandom_range(1, 4));
      if (dx < 0)
        dx = 0;
    end else if (pick == 1) begin
      // very tall source, clipped at the bottom edge
      w  = $urandom_range(1, 3);
      h  = $urandom_range(0, 8191);
      dy = scr_h_now - int'($urandom_range(1, 3));
      if (dy < 0)
        dy = 0;
    end else if (pick == 2) begin
      // empty source in one dimension
      if ($urandom_range(0, 1))
        w = 0;
      else
        h = 0;
    end
    if (mode == 9) begin
      repeat ($urandom_range(1, 3)) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      return;
    end
    cw = (dx + w > scr_w_now) ? scr_w_now - dx : w;
    ch = (dy + h > scr_h_now) ? scr_h_now - dy : h;
    needed = (cw > 0 && ch > 0) ? (ch - 1) * w + cw : 0;
    if (mode == 8)
      count = (needed > 1) ? $urandom_range(1, needed - 1) : 0;
    else
      count = needed + $urandom_range(0, 2);
    send_start(13'(w), 13'(h), 12'(dx), 12'(dy));
    repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(input bit calm);
    int sw, sh, stride, fmt, sel;
    sel = $urandom_range(0, 5);
    if (sel <= 2) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 10);
    end else if (sel == 3) begin
      sw = $urandom_range(0, 8191);
      sh = $urandom_range(0, 8191);
    end else if (sel == 4) begin
      sw = $urandom_range(0, 1) ? 8191 : MAX_DIM;
      sh = $urandom_range(0, 1) ? 8191 : MAX_DIM;
    end else begin
      sw = $urandom_range(13, 300);
      sh = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(11, 300);
    end
    stride = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
    sel = $urandom_range(0, 9);
    if (sel < 4)
      fmt = FMT_RGB565;
    else if (sel < 8)
      fmt = FMT_XRGB;
    else
      fmt = $urandom_range(0, 1) ? FMT_NONE_A : FMT_NONE_B;
    write_regs(sw, sh, stride, fmt, $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 31));
    gaps_on   = !calm && $urandom_range(0, 3) != 0;
    stalls_on = !calm && $urandom_range(0, 3) != 0;
    // sometimes pick up a blit left open across the register change
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    repeat ($urandom_range(5, 15)) random_blit();
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= REG_SCREEN_WIDTH;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_START;
    in_ch.src_width  <= '0;
    in_ch.src_height <= '0;
    in_ch.dest_x     <= '0;
    in_ch.dest_y     <= '0;
    in_ch.red        <= '0;
    in_ch.green      <= '0;
    in_ch.blue       <= '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    sent_words = 0;
    scr_w_now  = 640;
    scr_h_now  = 480;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset registers (640x480, 32-bit pixels).
    send_pixel(8'hFF, 8'h00, 8'hFF);              // no blit open: dropped
    send_start(13'd3, 13'd2, 12'd638, 12'd479);   // clipped right and bottom to 2x1
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);              // final visible word
    send_pixel(8'h5A, 8'hA5, 8'h3C);              // trailing source pixel: dropped
    send_start(13'd1, 13'd1, 12'd640, 12'd0);     // entirely off screen
    send_pixel(8'h12, 8'h34, 8'h56);
    send_start(13'd0, 13'd5, 12'd0, 12'd0);       // zero width
    send_start(13'd4, 13'd4, 12'd0, 12'd0);       // abandoned after two pixels
    send_pixel(8'h80, 8'h40, 8'h20);
    send_pixel(8'h01, 8'h02, 8'h04);
    send_start(13'd1, 13'd1, 12'd10, 12'd10);     // restart mid-blit
    send_pixel(8'hC3, 8'h3C, 8'h99);

    // Everything over range saturates; corner pixel at the top of the address space.
    write_regs(8191, 8191, 32767, FMT_RGB565, 31, 31, 31);
    send_start(13'd8191, 13'd8191, 12'd4095, 12'd4095);
    send_pixel(8'hFF, 8'hFF, 8'hFF);

    // Tiny screen, zero stride, shifts that push bits off the top.
    write_regs(4, 3, 0, FMT_XRGB, 31, 25, 24);
    send_start(13'd8191, 13'd1, 12'd0, 12'd0);
    repeat (4) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // Unsupported format: pixels counted, nothing written.
    write_regs(2, 2, MAX_STRIDE, FMT_NONE_A, 0, 0, 0);
    send_start(13'd2, 13'd2, 12'd0, 12'd0);
    repeat (4) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // Random phases, each with fresh registers; the tail runs flat out.
    while (sent_words < TARGET_WORDS - CALM_WORDS)
      random_phase(1'b0);
    do random_phase(1'b1); while (sent_words < TARGET_WORDS);

    settle();
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
